/* hdl/c8ic_pkg.sv */
// ----------------------------------------------------------------------------
// c8ic_pkg: shared types and constants of the CHIP-8 instruction core
// Opcode fields, command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package c8ic_pkg;

	// default geometry
	localparam int DEF_MEM_BYTES     = 4096;
	localparam int DEF_SCREEN_WIDTH  = 64;
	localparam int DEF_SCREEN_HEIGHT = 32;
	localparam int DEF_STACK_DEPTH   = 16;

	// reset values of the configuration registers, and the LFSR taps
	localparam logic [11:0] START_RESET = 12'd512;
	localparam logic [15:0] SEED_RESET  = 16'd44257;
	localparam logic [15:0] LFSR_TAPS   = 16'hB400;

	// configuration register indexes
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_SEED  = 1'b1;

	// host operations
	localparam logic [1:0] OPR_STEP   = 2'd0;
	localparam logic [1:0] OPR_MEM_WR = 2'd1;
	localparam logic [1:0] OPR_KEY    = 2'd2;
	localparam logic [1:0] OPR_PIXEL  = 2'd3;

	// result status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_HALT      = 3'd1;
	localparam logic [2:0] STS_ILLEGAL   = 3'd2;
	localparam logic [2:0] STS_OVERFLOW  = 3'd3;
	localparam logic [2:0] STS_UNDERFLOW = 3'd4;

	// instruction groups (top nibble)
	localparam logic [3:0] GRP_SYS   = 4'h0;
	localparam logic [3:0] GRP_JP    = 4'h1;
	localparam logic [3:0] GRP_CALL  = 4'h2;
	localparam logic [3:0] GRP_SE    = 4'h3;
	localparam logic [3:0] GRP_SNE   = 4'h4;
	localparam logic [3:0] GRP_SER   = 4'h5;
	localparam logic [3:0] GRP_LD    = 4'h6;
	localparam logic [3:0] GRP_ADD   = 4'h7;
	localparam logic [3:0] GRP_ALU   = 4'h8;
	localparam logic [3:0] GRP_SNER  = 4'h9;
	localparam logic [3:0] GRP_LDI   = 4'hA;
	localparam logic [3:0] GRP_JPV0  = 4'hB;
	localparam logic [3:0] GRP_RND   = 4'hC;
	localparam logic [3:0] GRP_DRAW  = 4'hD;
	localparam logic [3:0] GRP_KEY   = 4'hE;
	localparam logic [3:0] GRP_MISC  = 4'hF;

	localparam logic [15:0] OPC_CLS = 16'h00E0;
	localparam logic [15:0] OPC_RET = 16'h00EE;

	// 8XYN sub-operations
	localparam logic [3:0] ALU_LD   = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// EXNN / FXNN low bytes
	localparam logic [7:0] KEY_SKP     = 8'h9E;
	localparam logic [7:0] KEY_SKNP    = 8'hA1;
	localparam logic [7:0] FX_DELAY_RD = 8'h07;
	localparam logic [7:0] FX_KEY_WAIT = 8'h0A;
	localparam logic [7:0] FX_DELAY_WR = 8'h15;
	localparam logic [7:0] FX_SOUND_WR = 8'h18;
	localparam logic [7:0] FX_ADD_I    = 8'h1E;
	localparam logic [7:0] FX_FONT     = 8'h29;
	localparam logic [7:0] FX_BCD      = 8'h33;
	localparam logic [7:0] FX_STORE    = 8'h55;
	localparam logic [7:0] FX_LOAD     = 8'h65;

	localparam logic [3:0] VF_IDX = 4'hF;

	// execute classes decoded by the sequencer
	typedef enum logic [4:0] {
		EX_NONE, EX_CLS, EX_RET, EX_JP, EX_CALL, EX_SKIP, EX_LDNN, EX_ADDNN,
		EX_ALU, EX_LDI, EX_JPV0, EX_RND, EX_FX07, EX_FX0A, EX_FX15, EX_FX18,
		EX_FX1E, EX_FX29, EX_ADV
	} exec_t;

	// program memory address source
	typedef enum logic [1:0] {MS_PC, MS_PC1, MS_IDX, MS_HOST} msel_t;

	typedef struct packed {
		logic       accept_ld;
		logic       mem_re;
		logic       mem_we;
		msel_t      mem_sel;
		logic       ir_hi_ld;
		logic       ir_lo_ld;
		logic       rf_rd;
		logic       rf_rd_cnt;
		exec_t      exec;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       load_wr;
		logic       key_wr;
		logic       fb_rd;
		logic       fb_pix;
		logic       draw_wr;
		logic       draw_fin;
		logic       rsp_ld;
		logic       rsp_pix;
		logic [2:0] rsp_status;
	} cmd_t;

	typedef struct packed {
		logic [15:0] ir;
		logic [3:0]  cnt;
		logic        stk_empty;
		logic        stk_full;
		logic        rsp_busy;
	} sts_t;

endpackage

/* hdl/c8ic_datapath.sv */
// ----------------------------------------------------------------------------
// c8ic_datapath: CHIP-8 machine state and execution datapath
// Program memory, register file, frame buffer rows, stack, timers, result reg.
// ----------------------------------------------------------------------------
module c8ic_datapath #(
	parameter int MEM_BYTES     = 4096,
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32,
	parameter int STACK_DEPTH   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  c8ic_pkg::cmd_t cmd,
	output c8ic_pkg::sts_t sts,
	input  logic [11:0]   mem_address,
	input  logic [7:0]    mem_data,
	input  logic [3:0]    key_index,
	input  logic          key_down,
	input  logic [5:0]    pixel_x,
	input  logic [4:0]    pixel_y,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output logic [2:0]    status,
	output logic [11:0]   program_counter,
	output logic [11:0]   index_value,
	output logic [7:0]    flag_value,
	output logic          pixel_value,
	output logic [7:0]    sound_value,
	output logic          key_wait_pending,
	output logic [3:0]    key_wait_target
);
	import c8ic_pkg::*;

	localparam int AW  = $clog2(MEM_BYTES);
	localparam int XW  = $clog2(SCREEN_WIDTH);
	localparam int YW  = $clog2(SCREEN_HEIGHT);
	localparam int SIW = $clog2(STACK_DEPTH);
	localparam int SLW = $clog2(STACK_DEPTH + 1);

	// address modulo memory size, value below 16 * MEM_BYTES
	function automatic logic [AW-1:0] mem_wrap(input logic [12:0] a);
		logic [15:0] r;
		r = {3'b000, a};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (16'(MEM_BYTES) << k))
				r = r - (16'(MEM_BYTES) << k);
		end
		return r[AW-1:0];
	endfunction

	// screen coordinate modulo m, value below 64 * m
	function automatic logic [13:0] wrap9(input logic [8:0] v, input logic [13:0] m);
		logic [13:0] r;
		r = {5'b00000, v};
		for (int k = 5; k >= 0; k--) begin
			if (r >= (m << k))
				r = r - (m << k);
		end
		return r;
	endfunction

	// latched host fields
	logic [11:0] mem_address_q;
	logic [7:0]  mem_data_q;
	logic [3:0]  key_index_q;
	logic        key_down_q;
	logic [5:0]  pixel_x_q;
	logic [4:0]  pixel_y_q;

	// architectural state
	logic [11:0]        pc_q, idx_q;
	logic [SLW-1:0]     level_q;
	logic [11:0]        stk_q [STACK_DEPTH];
	logic [15:0]        lfsr_q;
	logic [7:0]         vf_q, delay_q, sound_q;
	logic               wait_p_q;
	logic [3:0]         wait_t_q;
	logic [15:0]        keys_q;
	logic [15:0]        ir_q;
	logic [3:0]         cnt_q;
	logic               hit_q;

	// memories
	logic [7:0]              pmem [MEM_BYTES];
	logic [7:0]              mem_rd_q;
	logic [7:0]              rf_mem [16];
	logic [15:0]             rfv_q;
	logic [7:0]              rf_a_q, rf_b_q;
	logic [SCREEN_WIDTH-1:0] fb_mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] fbv_q;
	logic [SCREEN_WIDTH-1:0] fb_row_q;

	// result register
	logic rsp_valid_q;

	// decoded fields
	logic [3:0]  x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn;
	assign x   = ir_q[11:8];
	assign y   = ir_q[7:4];
	assign n   = ir_q[3:0];
	assign nn  = ir_q[7:0];
	assign nnn = ir_q[11:0];

	logic [11:0] pc_next2, pc_skip;
	assign pc_next2 = pc_q + 12'd2;
	assign pc_skip  = pc_q + 12'd4;

	// program memory port
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wd;
	always_comb begin
		unique case (cmd.mem_sel)
			MS_PC:   mem_addr = mem_wrap({1'b0, pc_q});
			MS_PC1:  mem_addr = mem_wrap({1'b0, pc_q} + 13'd1);
			MS_IDX:  mem_addr = mem_wrap({1'b0, idx_q} + {9'd0, cnt_q});
			MS_HOST: mem_addr = mem_wrap({1'b0, mem_address_q});
			default: mem_addr = '0;
		endcase
		mem_wd = (cmd.mem_sel == MS_HOST) ? mem_data_q : rf_a_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			pmem[mem_addr] <= mem_wd;
		if (cmd.mem_re)
			mem_rd_q <= pmem[mem_addr];
	end

	// register file reads, VF lives in vf_q
	logic [3:0] ra;
	logic [7:0] rd_a, rd_b;
	always_comb begin
		ra = cmd.rf_rd_cnt ? cnt_q : ((ir_q[15:12] == GRP_JPV0) ? 4'h0 : x);
		rd_a = (ra == VF_IDX) ? vf_q : (rfv_q[ra] ? rf_mem[ra] : 8'h00);
		rd_b = (y == VF_IDX) ? vf_q : (rfv_q[y] ? rf_mem[y] : 8'h00);
	end

	// ALU
	logic [8:0] sum;
	logic [7:0] alu_r;
	logic       alu_f, alu_fw;
	always_comb begin
		sum    = {1'b0, rf_a_q} + {1'b0, rf_b_q};
		alu_r  = rf_b_q;
		alu_f  = 1'b0;
		alu_fw = 1'b0;
		unique case (n)
			ALU_LD:   alu_r = rf_b_q;
			ALU_OR:   alu_r = rf_a_q | rf_b_q;
			ALU_AND:  alu_r = rf_a_q & rf_b_q;
			ALU_XOR:  alu_r = rf_a_q ^ rf_b_q;
			ALU_ADD: begin
				alu_r = sum[7:0]; alu_f = sum[8]; alu_fw = 1'b1;
			end
			ALU_SUB: begin
				alu_r = rf_a_q - rf_b_q; alu_f = (rf_a_q >= rf_b_q); alu_fw = 1'b1;
			end
			ALU_SHR: begin
				alu_r = {1'b0, rf_b_q[7:1]}; alu_f = rf_b_q[0]; alu_fw = 1'b1;
			end
			ALU_SUBN: begin
				alu_r = rf_b_q - rf_a_q; alu_f = (rf_b_q >= rf_a_q); alu_fw = 1'b1;
			end
			ALU_SHL: begin
				alu_r = {rf_b_q[6:0], 1'b0}; alu_f = rf_b_q[7]; alu_fw = 1'b1;
			end
			default: alu_r = rf_b_q;
		endcase
	end

	logic [15:0] lfsr_nx;
	assign lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);

	// register file write port
	logic       rf_we, flag_we;
	logic [3:0] rf_wa;
	logic [7:0] rf_wd;
	always_comb begin
		rf_we = 1'b0;
		rf_wa = x;
		rf_wd = 8'h00;
		if (cmd.load_wr) begin
			rf_we = 1'b1; rf_wa = cnt_q; rf_wd = mem_rd_q;
		end else begin
			unique case (cmd.exec)
				EX_LDNN:  begin rf_we = 1'b1; rf_wd = nn; end
				EX_ADDNN: begin rf_we = 1'b1; rf_wd = rf_a_q + nn; end
				EX_ALU:   begin rf_we = 1'b1; rf_wd = alu_r; end
				EX_RND:   begin rf_we = 1'b1; rf_wd = lfsr_nx[7:0] & nn; end
				EX_FX07:  begin rf_we = 1'b1; rf_wd = delay_q; end
				default:  rf_we = 1'b0;
			endcase
		end
		flag_we = (cmd.exec == EX_ALU) && alu_fw;
	end

	// skip condition
	logic skip_c, key_hit;
	always_comb begin
		key_hit = keys_q[rf_a_q[3:0]];
		unique case (ir_q[15:12])
			GRP_SE:   skip_c = (rf_a_q == nn);
			GRP_SNE:  skip_c = (rf_a_q != nn);
			GRP_SER:  skip_c = (rf_a_q == rf_b_q);
			GRP_SNER: skip_c = (rf_a_q != rf_b_q);
			GRP_KEY:  skip_c = (nn == KEY_SKP) ? key_hit : !key_hit;
			default:  skip_c = 1'b0;
		endcase
	end

	// frame buffer geometry
	logic [13:0]             x0_w, dy_w, px_w, py_w;
	logic [XW-1:0]           x0, px;
	logic [YW-1:0]           draw_row, pix_row, fb_ra;
	logic [SCREEN_WIDTH-1:0] mask;
	logic [XW:0]             col;
	always_comb begin
		x0_w = wrap9({1'b0, rf_a_q}, 14'(SCREEN_WIDTH));
		dy_w = wrap9({1'b0, rf_b_q} + {5'd0, cnt_q}, 14'(SCREEN_HEIGHT));
		px_w = wrap9({3'b000, pixel_x_q}, 14'(SCREEN_WIDTH));
		py_w = wrap9({4'b0000, pixel_y_q}, 14'(SCREEN_HEIGHT));
		x0       = x0_w[XW-1:0];
		px       = px_w[XW-1:0];
		draw_row = dy_w[YW-1:0];
		pix_row  = py_w[YW-1:0];
		fb_ra    = cmd.fb_pix ? pix_row : draw_row;
		mask     = '0;
		for (int c = 0; c < 8; c++) begin
			col = {1'b0, x0} + (XW+1)'(c);
			if (col >= (XW+1)'(SCREEN_WIDTH))
				col = col - (XW+1)'(SCREEN_WIDTH);
			if (mem_rd_q[7-c])
				mask[col[XW-1:0]] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fb_rd)
			fb_row_q <= fbv_q[fb_ra] ? fb_mem[fb_ra] : '0;
		if (cmd.draw_wr)
			fb_mem[draw_row] <= fb_row_q ^ mask;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept_ld) begin
			mem_address_q <= mem_address;
			mem_data_q    <= mem_data;
			key_index_q   <= key_index;
			key_down_q    <= key_down;
			pixel_x_q     <= pixel_x;
			pixel_y_q     <= pixel_y;
		end
		if (cmd.ir_hi_ld)
			ir_q[15:8] <= mem_rd_q;
		if (cmd.ir_lo_ld)
			ir_q[7:0] <= mem_rd_q;
		if (cmd.rf_rd || cmd.rf_rd_cnt)
			rf_a_q <= rd_a;
		if (cmd.rf_rd)
			rf_b_q <= rd_b;
		if (rf_we && rf_wa != VF_IDX)
			rf_mem[rf_wa] <= rf_wd;
		if (cmd.exec == EX_CALL)
			stk_q[level_q[SIW-1:0]] <= pc_next2;
		if (cmd.rsp_ld) begin
			status           <= cmd.rsp_status;
			program_counter  <= pc_q;
			index_value      <= idx_q;
			flag_value       <= vf_q;
			pixel_value      <= cmd.rsp_pix ? fb_row_q[px] : 1'b0;
			sound_value      <= sound_q;
			key_wait_pending <= wait_p_q;
			key_wait_target  <= wait_t_q;
		end
	end

	logic [SLW-1:0] level_m1;
	assign level_m1 = level_q - SLW'(1);

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= START_RESET;
			idx_q       <= '0;
			level_q     <= '0;
			lfsr_q      <= SEED_RESET;
			vf_q        <= '0;
			delay_q     <= '0;
			sound_q     <= '0;
			wait_p_q    <= 1'b0;
			wait_t_q    <= '0;
			keys_q      <= '0;
			rfv_q       <= '0;
			fbv_q       <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_START)
					pc_q <= cfg_data[11:0];
				else
					lfsr_q <= cfg_data;
			end
			unique case (cmd.exec)
				EX_CLS: begin
					fbv_q <= '0; pc_q <= pc_next2;
				end
				EX_RET: begin
					pc_q <= stk_q[level_m1[SIW-1:0]]; level_q <= level_m1;
				end
				EX_JP:   pc_q <= nnn;
				EX_CALL: begin
					pc_q <= nnn; level_q <= level_q + SLW'(1);
				end
				EX_SKIP: pc_q <= skip_c ? pc_skip : pc_next2;
				EX_JPV0: pc_q <= {4'h0, rf_a_q} + nnn;
				EX_LDI: begin
					idx_q <= nnn; pc_q <= pc_next2;
				end
				EX_RND: begin
					lfsr_q <= lfsr_nx; pc_q <= pc_next2;
				end
				EX_FX0A: begin
					wait_p_q <= 1'b1; wait_t_q <= x; pc_q <= pc_next2;
				end
				EX_FX15: begin
					delay_q <= rf_a_q; pc_q <= pc_next2;
				end
				EX_FX18: begin
					sound_q <= rf_a_q; pc_q <= pc_next2;
				end
				EX_FX1E: begin
					idx_q <= idx_q + {4'h0, rf_a_q}; pc_q <= pc_next2;
				end
				EX_FX29: begin
					idx_q <= {2'b00, rf_a_q, 2'b00} + {4'h0, rf_a_q}; pc_q <= pc_next2;
				end
				EX_LDNN, EX_ADDNN, EX_ALU, EX_FX07, EX_ADV: pc_q <= pc_next2;
				default: ;
			endcase
			if (rf_we && rf_wa != VF_IDX)
				rfv_q[rf_wa] <= 1'b1;
			// flag write wins over a plain write of VF
			if (flag_we)
				vf_q <= {7'd0, alu_f};
			else if (cmd.draw_fin)
				vf_q <= {7'd0, hit_q};
			else if (rf_we && rf_wa == VF_IDX)
				vf_q <= rf_wd;
			if (cmd.key_wr)
				keys_q[key_index_q] <= key_down_q;
			if (cmd.draw_wr) begin
				fbv_q[draw_row] <= 1'b1;
				hit_q <= hit_q | (|(fb_row_q & mask));
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0; hit_q <= 1'b0;
			end else if (cmd.cnt_inc)
				cnt_q <= cnt_q + 4'd1;
			if (cmd.rsp_ld)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.ir        = ir_q;
		sts.cnt       = cnt_q;
		sts.stk_empty = (level_q == '0);
		sts.stk_full  = (level_q >= SLW'(STACK_DEPTH));
		sts.rsp_busy  = rsp_valid_q && rsp_stall;
	end

endmodule

/* hdl/c8ic_control.sv */
// ----------------------------------------------------------------------------
// c8ic_control: sequencer of the CHIP-8 instruction core
// Fetch, decode, legality checks and multi-cycle walks for draw and block moves.
// ----------------------------------------------------------------------------
module c8ic_control (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic [1:0]     operation,
	output logic           cmd_stall,
	input  c8ic_pkg::sts_t sts,
	output c8ic_pkg::cmd_t cmd
);
	import c8ic_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_HOST   = 5'd1;
	localparam logic [4:0] S_PIX    = 5'd2;
	localparam logic [4:0] S_F0     = 5'd3;
	localparam logic [4:0] S_F1     = 5'd4;
	localparam logic [4:0] S_F2     = 5'd5;
	localparam logic [4:0] S_DEC    = 5'd6;
	localparam logic [4:0] S_EXE    = 5'd7;
	localparam logic [4:0] S_DR_MEM = 5'd8;
	localparam logic [4:0] S_DR_ROW = 5'd9;
	localparam logic [4:0] S_DR_WR  = 5'd10;
	localparam logic [4:0] S_ST_RD  = 5'd11;
	localparam logic [4:0] S_ST_WR  = 5'd12;
	localparam logic [4:0] S_LD_RD  = 5'd13;
	localparam logic [4:0] S_LD_WR  = 5'd14;
	localparam logic [4:0] S_FIN    = 5'd15;
	localparam logic [4:0] S_RESP   = 5'd16;

	logic [4:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic [2:0] status_q, status_d;

	logic [3:0] grp, x, n;
	logic [7:0] nn;
	assign grp = sts.ir[15:12];
	assign x   = sts.ir[11:8];
	assign n   = sts.ir[3:0];
	assign nn  = sts.ir[7:0];

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.exec     = EX_NONE;
		cmd.mem_sel  = MS_PC;
		state_d      = state_q;
		op_d         = op_q;
		status_d     = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.accept_ld = 1'b1;
					op_d          = operation;
					status_d      = STS_OK;
					unique case (operation)
						OPR_STEP:  state_d = S_F0;
						OPR_PIXEL: state_d = S_PIX;
						default:   state_d = S_HOST;
					endcase
				end
			end
			S_HOST: begin
				if (op_q == OPR_MEM_WR) begin
					cmd.mem_we  = 1'b1;
					cmd.mem_sel = MS_HOST;
				end else
					cmd.key_wr = 1'b1;
				state_d = S_RESP;
			end
			S_PIX: begin
				cmd.fb_rd  = 1'b1;
				cmd.fb_pix = 1'b1;
				state_d    = S_RESP;
			end
			S_F0: begin
				cmd.mem_re = 1'b1;
				state_d    = S_F1;
			end
			S_F1: begin
				cmd.ir_hi_ld = 1'b1;
				cmd.mem_re   = 1'b1;
				cmd.mem_sel  = MS_PC1;
				state_d      = S_F2;
			end
			S_F2: begin
				cmd.ir_lo_ld = 1'b1;
				state_d      = S_DEC;
			end
			S_DEC: begin
				cmd.rf_rd = 1'b1;
				state_d   = S_EXE;
			end
			S_EXE: begin
				state_d = S_RESP;
				unique case (grp)
					GRP_SYS: begin
						if (sts.ir == OPC_CLS)
							cmd.exec = EX_CLS;
						else if (sts.ir == OPC_RET) begin
							if (sts.stk_empty)
								status_d = STS_UNDERFLOW;
							else
								cmd.exec = EX_RET;
						end else
							status_d = STS_HALT;
					end
					GRP_JP: cmd.exec = EX_JP;
					GRP_CALL: begin
						if (sts.stk_full)
							status_d = STS_OVERFLOW;
						else
							cmd.exec = EX_CALL;
					end
					GRP_SE, GRP_SNE: cmd.exec = EX_SKIP;
					GRP_SER, GRP_SNER: begin
						if (n != 4'h0)
							status_d = STS_ILLEGAL;
						else
							cmd.exec = EX_SKIP;
					end
					GRP_LD:  cmd.exec = EX_LDNN;
					GRP_ADD: cmd.exec = EX_ADDNN;
					GRP_ALU: begin
						if (n == ALU_LD || n == ALU_OR || n == ALU_AND || n == ALU_XOR ||
							n == ALU_ADD || n == ALU_SUB || n == ALU_SHR || n == ALU_SUBN ||
							n == ALU_SHL)
							cmd.exec = EX_ALU;
						else
							status_d = STS_ILLEGAL;
					end
					GRP_LDI:  cmd.exec = EX_LDI;
					GRP_JPV0: cmd.exec = EX_JPV0;
					GRP_RND:  cmd.exec = EX_RND;
					GRP_DRAW: begin
						cmd.cnt_clr = 1'b1;
						state_d     = (n == 4'h0) ? S_FIN : S_DR_MEM;
					end
					GRP_KEY: begin
						if (nn == KEY_SKP || nn == KEY_SKNP)
							cmd.exec = EX_SKIP;
						else
							status_d = STS_ILLEGAL;
					end
					GRP_MISC: begin
						unique case (nn)
							FX_DELAY_RD: cmd.exec = EX_FX07;
							FX_KEY_WAIT: cmd.exec = EX_FX0A;
							FX_DELAY_WR: cmd.exec = EX_FX15;
							FX_SOUND_WR: cmd.exec = EX_FX18;
							FX_ADD_I:    cmd.exec = EX_FX1E;
							FX_FONT:     cmd.exec = EX_FX29;
							FX_BCD:      cmd.exec = EX_ADV;
							FX_STORE: begin
								cmd.cnt_clr = 1'b1;
								state_d     = S_ST_RD;
							end
							FX_LOAD: begin
								cmd.cnt_clr = 1'b1;
								state_d     = S_LD_RD;
							end
							default: status_d = STS_ILLEGAL;
						endcase
					end
					default: status_d = STS_ILLEGAL;
				endcase
			end
			S_DR_MEM: begin
				cmd.mem_re  = 1'b1;
				cmd.mem_sel = MS_IDX;
				state_d     = S_DR_ROW;
			end
			S_DR_ROW: begin
				cmd.fb_rd = 1'b1;
				state_d   = S_DR_WR;
			end
			S_DR_WR: begin
				cmd.draw_wr = 1'b1;
				if (sts.cnt == n - 4'd1)
					state_d = S_FIN;
				else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_DR_MEM;
				end
			end
			S_ST_RD: begin
				cmd.rf_rd_cnt = 1'b1;
				state_d       = S_ST_WR;
			end
			S_ST_WR: begin
				cmd.mem_we  = 1'b1;
				cmd.mem_sel = MS_IDX;
				if (sts.cnt == x)
					state_d = S_FIN;
				else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_ST_RD;
				end
			end
			S_LD_RD: begin
				cmd.mem_re  = 1'b1;
				cmd.mem_sel = MS_IDX;
				state_d     = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.load_wr = 1'b1;
				if (sts.cnt == x)
					state_d = S_FIN;
				else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_LD_RD;
				end
			end
			S_FIN: begin
				cmd.exec     = EX_ADV;
				cmd.draw_fin = (grp == GRP_DRAW);
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (!sts.rsp_busy) begin
					cmd.rsp_ld     = 1'b1;
					cmd.rsp_status = status_q;
					cmd.rsp_pix    = (op_q == OPR_PIXEL);
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OPR_STEP;
			status_q <= STS_OK;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			status_q <= status_d;
		end
	end

endmodule

/* hdl/chip8_instruction_core.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 instruction core, top level
// Host channel in, one result per transaction out, register write port.
// ----------------------------------------------------------------------------
// Use: the host sends a transaction on cmd_* (operation plus its fields); a
// transaction is taken on a clock edge with cmd_valid high and cmd_stall low.
// Operation 0 runs one instruction, 1 writes a program byte, 2 sets a key,
// 3 reads a pixel. Each transaction yields exactly one result on rsp_*,
// taken when rsp_valid is high and rsp_stall low.
// One transaction is in flight at a time, so the next one can be taken in
// the cycle after the result is loaded; the sequencer walk (fetch over the
// single program memory port, then the per-row read-modify-write of the
// frame buffer) sets the pace of the transactions.
// The result register lets the next transaction be taken while a result
// waits; a stalled result holds the sequencer in its response state.
// Reset: registers cleared, PC = 512, LFSR = 44257, screen cleared at once by
// per-row valid bits; program memory and return stack are not initialized.
// cfg_ready is always high; write start_address (index 0) or random_seed
// (index 1) only while no transaction is in flight.
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
	parameter int MEM_BYTES     = c8ic_pkg::DEF_MEM_BYTES,
	parameter int SCREEN_WIDTH  = c8ic_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = c8ic_pkg::DEF_SCREEN_HEIGHT,
	parameter int STACK_DEPTH   = c8ic_pkg::DEF_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// host transaction channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic [11:0] mem_address,
	input  logic [7:0]  mem_data,
	input  logic [3:0]  key_index,
	input  logic        key_down,
	input  logic [5:0]  pixel_x,
	input  logic [4:0]  pixel_y,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [11:0] program_counter,
	output logic [11:0] index_value,
	output logic [7:0]  flag_value,
	output logic        pixel_value,
	output logic [7:0]  sound_value,
	output logic        key_wait_pending,
	output logic [3:0]  key_wait_target,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import c8ic_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: fetch, decode, multi-cycle walks, response handshake
	c8ic_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.operation (operation),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// machine state, memories and result register
	c8ic_datapath #(
		.MEM_BYTES     (MEM_BYTES),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mem_address      (mem_address),
		.mem_data         (mem_data),
		.key_index        (key_index),
		.key_down         (key_down),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rsp_stall        (rsp_stall),
		.rsp_valid        (rsp_valid),
		.status           (status),
		.program_counter  (program_counter),
		.index_value      (index_value),
		.flag_value       (flag_value),
		.pixel_value      (pixel_value),
		.sound_value      (sound_value),
		.key_wait_pending (key_wait_pending),
		.key_wait_target  (key_wait_target)
	);

endmodule

/* hdl/c8ic_checker.sv */
// ----------------------------------------------------------------------------
// c8ic_checker: port-level checks of the CHIP-8 instruction core
// Handshake and sequencing properties, bound to the top level.
// ----------------------------------------------------------------------------
module c8ic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [11:0] program_counter,
	input logic [2:0]  status
);

	// a taken transaction blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("cmd_stall low right after an accepted transaction");

	// no result appears in the cycle after an accept
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> !$rose(rsp_valid))
		else $error("result raised too early after accept");

	// a stalled result stays valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> rsp_valid)
		else $error("stalled result dropped");

	// a stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> ($stable(program_counter) && $stable(status)))
		else $error("stalled result payload changed");

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CHIP-8 instruction core
// Directed table, then random instruction streams with every byte they read
// written first, checked field by field against an in-bench model of the core.
// ----------------------------------------------------------------------------
module tb_top;
	import c8ic_pkg::*;

	localparam int WDOG_LIMIT = 3000;
	localparam int LONG_HOLD  = 80;
	localparam int RAND_ITEMS = 500;
	localparam int QUIET_FROM = 440;

	// one result transaction
	typedef struct {
		logic [2:0]  st;
		logic [11:0] pc;
		logic [11:0] idx;
		logic [7:0]  vf;
		logic        pix;
		logic [7:0]  snd;
		logic        wpend;
		logic [3:0]  wtgt;
	} core_result_t;

	// directed row; st/pc are typed in only where chk is set
	typedef struct {
		logic [1:0]  op;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [3:0]  kidx;
		logic        kdn;
		logic [5:0]  px;
		logic [4:0]  py;
		bit          chk;
		logic [2:0]  st;
		logic [11:0] pc;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	logic [1:0]  operation;
	logic [11:0] mem_address;
	logic [7:0]  mem_data;
	logic [3:0]  key_index;
	logic        key_down;
	logic [5:0]  pixel_x;
	logic [4:0]  pixel_y;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [2:0]  status;
	logic [11:0] program_counter;
	logic [11:0] index_value;
	logic [7:0]  flag_value;
	logic        pixel_value;
	logic [7:0]  sound_value;
	logic        key_wait_pending;
	logic [3:0]  key_wait_target;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	chip8_instruction_core uut (.*);

	// model state of the core
	logic [7:0]  vreg [16];
	logic [11:0] pc_m, idx_m;
	logic [11:0] ret_stack [16];
	int          sp_m;
	bit          screen [2048];
	logic [7:0]  prog_mem [4096];
	bit          written [4096];   // program bytes that hold a defined value
	bit          keypad [16];
	logic [7:0]  delay_m, sound_m;
	logic        wait_m;
	logic [3:0]  wait_reg_m;
	logic [15:0] lfsr_m;

	core_result_t pending_results[$];
	int  errors = 0;
	bit  quiet = 0;       // no idling on either side near the end
	bit  hold_req = 0;    // ask the receiver for one long hold-off
	int  idle_cycles = 0;

	// clock: period 8
	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	task automatic report(string what, logic [15:0] got, logic [15:0] exp);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// one instruction fetched at pc_m; returns the status code
	function automatic logic [2:0] run_instruction();
		logic [15:0] op;
		logic [3:0]  x, y, n;
		logic [7:0]  nn, vx, vy, bits;
		logic [11:0] nnn, nxt, skp;
		logic [8:0]  sum;
		logic [2:0]  st;
		bit          adv, hit;
		int          p;
		op  = {prog_mem[pc_m], prog_mem[12'(pc_m + 1)]};
		x   = op[11:8];
		y   = op[7:4];
		n   = op[3:0];
		nn  = op[7:0];
		nnn = op[11:0];
		vx  = vreg[x];
		vy  = vreg[y];
		nxt = pc_m + 12'd2;
		skp = pc_m + 12'd4;
		st  = STS_OK;
		adv = 1;
		case (op[15:12])
			GRP_SYS: begin
				if (op == OPC_CLS) begin
					foreach (screen[i]) screen[i] = 0;
				end else if (op == OPC_RET) begin
					adv = 0;
					if (sp_m == 0) st = STS_UNDERFLOW;
					else begin
						sp_m--;
						pc_m = ret_stack[sp_m];
					end
				end else st = STS_HALT;
			end
			GRP_JP: begin
				pc_m = nnn;
				adv = 0;
			end
			GRP_CALL: begin
				adv = 0;
				if (sp_m >= 16) st = STS_OVERFLOW;
				else begin
					ret_stack[sp_m] = nxt;
					sp_m++;
					pc_m = nnn;
				end
			end
			GRP_SE: begin
				pc_m = (vx == nn) ? skp : nxt;
				adv = 0;
			end
			GRP_SNE: begin
				pc_m = (vx != nn) ? skp : nxt;
				adv = 0;
			end
			GRP_SER, GRP_SNER: begin
				adv = 0;
				if (n != 0) st = STS_ILLEGAL;
				else if (op[15:12] == GRP_SER) pc_m = (vx == vy) ? skp : nxt;
				else pc_m = (vx != vy) ? skp : nxt;
			end
			GRP_LD:  vreg[x] = nn;
			GRP_ADD: vreg[x] = vx + nn;
			GRP_ALU: begin
				case (n)
					ALU_LD:  vreg[x] = vy;
					ALU_OR:  vreg[x] = vx | vy;
					ALU_AND: vreg[x] = vx & vy;
					ALU_XOR: vreg[x] = vx ^ vy;
					ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						vreg[x] = sum[7:0];
						vreg[VF_IDX] = {7'd0, sum[8]};
					end
					ALU_SUB: begin
						vreg[x] = vx - vy;
						vreg[VF_IDX] = {7'd0, vx >= vy};
					end
					ALU_SHR: begin
						vreg[x] = vy >> 1;
						vreg[VF_IDX] = {7'd0, vy[0]};
					end
					ALU_SUBN: begin
						vreg[x] = vy - vx;
						vreg[VF_IDX] = {7'd0, vy >= vx};
					end
					ALU_SHL: begin
						vreg[x] = vy << 1;
						vreg[VF_IDX] = {7'd0, vy[7]};
					end
					default: st = STS_ILLEGAL;
				endcase
			end
			GRP_LDI: idx_m = nnn;
			GRP_JPV0: begin
				pc_m = 12'(vreg[0]) + nnn;
				adv = 0;
			end
			GRP_RND: begin
				lfsr_m = {1'b0, lfsr_m[15:1]} ^ (lfsr_m[0] ? LFSR_TAPS : 16'd0);
				vreg[x] = lfsr_m[7:0] & nn;
			end
			GRP_DRAW: begin
				hit = 0;
				for (int r = 0; r < n; r++) begin
					bits = prog_mem[12'(idx_m + r)];
					for (int c = 0; c < 8; c++) begin
						if (bits[7 - c]) begin
							p = ((vy + r) % 32) * 64 + (vx + c) % 64;
							if (screen[p]) hit = 1;
							screen[p] ^= 1;
						end
					end
				end
				vreg[VF_IDX] = {7'd0, hit};
			end
			GRP_KEY: begin
				adv = 0;
				if (nn == KEY_SKP) pc_m = keypad[vx[3:0]] ? skp : nxt;
				else if (nn == KEY_SKNP) pc_m = keypad[vx[3:0]] ? nxt : skp;
				else st = STS_ILLEGAL;
			end
			default: begin
				case (nn)
					FX_DELAY_RD: vreg[x] = delay_m;
					FX_KEY_WAIT: begin
						wait_m = 1;
						wait_reg_m = x;
					end
					FX_DELAY_WR: delay_m = vx;
					FX_SOUND_WR: sound_m = vx;
					FX_ADD_I:    idx_m = idx_m + 12'(vx);
					FX_FONT:     idx_m = 12'(vx * 5);
					FX_BCD:      ;
					FX_STORE: begin
						for (int i = 0; i <= x; i++) begin
							prog_mem[12'(idx_m + i)] = vreg[i];
							written[12'(idx_m + i)]  = 1;
						end
					end
					FX_LOAD:     for (int i = 0; i <= x; i++) vreg[i] = prog_mem[12'(idx_m + i)];
					default:     st = STS_ILLEGAL;
				endcase
			end
		endcase
		if (st == STS_OK && adv) pc_m = nxt;
		return st;
	endfunction

	// apply one accepted transaction to the model and queue its result
	function automatic core_result_t predict_result(logic [1:0] op, logic [11:0] addr,
			logic [7:0] data, logic [3:0] kidx, logic kdn, logic [5:0] px, logic [4:0] py);
		core_result_t r;
		r.st  = STS_OK;
		r.pix = 0;
		case (op)
			OPR_STEP:   r.st = run_instruction();
			OPR_MEM_WR: begin
				prog_mem[addr] = data;
				written[addr]  = 1;
			end
			OPR_KEY:    keypad[kidx] = kdn;
			default:    r.pix = screen[py * 64 + px];
		endcase
		r.pc    = pc_m;
		r.idx   = idx_m;
		r.vf    = vreg[VF_IDX];
		r.snd   = sound_m;
		r.wpend = wait_m;
		r.wtgt  = wait_reg_m;
		pending_results.push_back(r);
		return r;
	endfunction

	// random instruction, weighted toward legal encodings
	function automatic logic [15:0] make_instruction();
		logic [15:0] ins;
		logic [7:0]  fx_ops [9];
		logic [3:0]  alu_ops [9];
		fx_ops  = '{FX_DELAY_RD, FX_KEY_WAIT, FX_DELAY_WR, FX_SOUND_WR, FX_ADD_I,
			FX_FONT, FX_BCD, FX_STORE, FX_LOAD};
		alu_ops = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
			ALU_SUBN, ALU_SHL};
		ins = 16'($urandom);
		if ($urandom_range(0, 5) == 0) ins[15:12] = GRP_CALL;   // drive the stack deep
		case (ins[15:12])
			GRP_SYS: begin
				case ($urandom_range(0, 5))
					0:       ins = OPC_CLS;
					1, 2, 3: ins = OPC_RET;
					default: ;
				endcase
			end
			GRP_SER, GRP_SNER: if ($urandom_range(0, 4) != 0) ins[3:0] = 0;
			GRP_ALU: if ($urandom_range(0, 7) != 0) ins[3:0] = alu_ops[$urandom_range(0, 8)];
			GRP_KEY: if ($urandom_range(0, 7) != 0)
				ins[7:0] = $urandom_range(0, 1) ? KEY_SKP : KEY_SKNP;
			GRP_MISC: if ($urandom_range(0, 7) != 0) ins[7:0] = fx_ops[$urandom_range(0, 8)];
			default: ;
		endcase
		return ins;
	endfunction

	// offer one transaction; returns at the edge that takes it
	task automatic send_item(logic [1:0] op, logic [11:0] addr, logic [7:0] data,
			logic [3:0] kidx, logic kdn, logic [5:0] px, logic [4:0] py);
		core_result_t r;
		cmd_valid   <= 1;
		operation   <= op;
		mem_address <= addr;
		mem_data    <= data;
		key_index   <= kidx;
		key_down    <= kdn;
		pixel_x     <= px;
		pixel_y     <= py;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		r = predict_result(op, addr, data, kidx, kdn, px, py);
	endtask

	// random sender gap with cmd_valid low, skipped once quiet is set
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			cmd_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// give a program byte a value before anything reads it
	task automatic ensure_written(logic [11:0] a);
		if (!written[a]) begin
			send_item(OPR_MEM_WR, a, 8'($urandom), 4'($urandom), 1'($urandom), 6'($urandom),
				5'($urandom));
			maybe_gap();
		end
	endtask

	// bytes read through I by a draw or a register load
	task automatic cover_reads(logic [15:0] ins);
		logic [11:0] base;
		int          cnt;
		base = idx_m;
		cnt  = 0;
		if (ins[15:12] == GRP_DRAW) cnt = int'(ins[3:0]);
		else if (ins[15:12] == GRP_MISC && ins[7:0] == FX_LOAD) cnt = int'(ins[11:8]) + 1;
		for (int i = 0; i < cnt; i++) ensure_written(base + 12'(i));
	endtask

	// register write, only with nothing in flight
	task automatic write_config(logic idx, logic [15:0] value);
		cmd_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_START) pc_m = value[11:0];
		else lfsr_m = value;
	endtask

	task automatic random_op();
		logic [15:0] ins;
		int          sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			// well-formed: plant an instruction at the PC, then run it
			ins = make_instruction();
			send_item(OPR_MEM_WR, pc_m, ins[15:8], 4'($urandom), 1'($urandom), 6'($urandom),
				5'($urandom));
			maybe_gap();
			send_item(OPR_MEM_WR, pc_m + 12'd1, ins[7:0], 4'($urandom), 1'($urandom),
				6'($urandom), 5'($urandom));
			maybe_gap();
			cover_reads(ins);
			send_item(OPR_STEP, 12'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
				6'($urandom), 5'($urandom));
		end else if (sel < 80) begin
			// run whatever sits at the PC, once its bytes are defined
			ensure_written(pc_m);
			ensure_written(pc_m + 12'd1);
			cover_reads({prog_mem[pc_m], prog_mem[pc_m + 12'd1]});
			send_item(OPR_STEP, 12'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
				6'($urandom), 5'($urandom));
		end else begin
			send_item(sel < 88 ? OPR_PIXEL : sel < 94 ? OPR_KEY : OPR_MEM_WR,
				12'($urandom), 8'($urandom), 4'($urandom), 1'($urandom), 6'($urandom),
				5'($urandom));
		end
	endtask

	dir_row_t dir_rows [25] = '{
		'{OPR_PIXEL,  12'h000, 8'h00, 4'd0,  1'b0, 6'd63, 5'd31, 1, STS_OK,        12'd512},
		'{OPR_PIXEL,  12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_OK,        12'd512},
		'{OPR_MEM_WR, 12'h200, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'h201, 8'h01, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_HALT,      12'd512},
		'{OPR_MEM_WR, 12'h201, 8'hEE, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_UNDERFLOW, 12'd512},
		'{OPR_MEM_WR, 12'h200, 8'h51, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'h201, 8'h21, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_ILLEGAL,   12'd512},
		'{OPR_MEM_WR, 12'h200, 8'hF0, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'h201, 8'hFF, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_ILLEGAL,   12'd512},
		'{OPR_MEM_WR, 12'h200, 8'hE0, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_ILLEGAL,   12'd512},
		'{OPR_KEY,    12'h000, 8'h00, 4'd15, 1'b1, 6'd0,  5'd0,  1, STS_OK,        12'd512},
		'{OPR_KEY,    12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'hFFF, 8'hFF, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_OK,        12'd512},
		'{OPR_MEM_WR, 12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		// VF loaded with all ones, then a screen clear
		'{OPR_MEM_WR, 12'h200, 8'h6F, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'h201, 8'hFF, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_OK,        12'd514},
		'{OPR_MEM_WR, 12'h202, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_MEM_WR, 12'h203, 8'hE0, 4'd0,  1'b0, 6'd0,  5'd0,  0, STS_OK,        12'd0},
		'{OPR_STEP,   12'h000, 8'h00, 4'd0,  1'b0, 6'd0,  5'd0,  1, STS_OK,        12'd516}
	};

	// main stimulus
	initial begin
		arst_n      = 0;
		cmd_valid   = 0;
		operation   = OPR_STEP;
		mem_address = 0;
		mem_data    = 0;
		key_index   = 0;
		key_down    = 0;
		pixel_x     = 0;
		pixel_y     = 0;
		cfg_valid   = 0;
		cfg_index   = CFG_START;
		cfg_data    = 0;
		foreach (vreg[i]) vreg[i] = 0;
		foreach (screen[i]) screen[i] = 0;
		foreach (keypad[i]) keypad[i] = 0;
		foreach (prog_mem[i]) prog_mem[i] = 0;
		foreach (written[i]) written[i] = 0;
		pc_m       = START_RESET;
		idx_m      = 0;
		sp_m       = 0;
		delay_m    = 0;
		sound_m    = 0;
		wait_m     = 0;
		wait_reg_m = 0;
		lfsr_m     = SEED_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; typed-in values cross-check the model
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].kidx,
				dir_rows[i].kdn, dir_rows[i].px, dir_rows[i].py);
			if (dir_rows[i].chk) begin
				if (pending_results[$].st !== dir_rows[i].st)
					report("directed status", 16'(pending_results[$].st), 16'(dir_rows[i].st));
				if (pending_results[$].pc !== dir_rows[i].pc)
					report("directed pc", 16'(pending_results[$].pc), 16'(dir_rows[i].pc));
			end
			maybe_gap();
		end

		for (int k = 0; k < RAND_ITEMS; k++) begin
			if (k == 100) hold_req = 1;
			if (k == 150) begin
				write_config(CFG_START, 16'd0);
				write_config(CFG_SEED, 16'd1);
			end
			if (k == 300) begin
				write_config(CFG_START, 16'd4095);
				write_config(CFG_SEED, 16'hFFFF);
			end
			if (k == 380) begin
				write_config(CFG_START, 16'($urandom_range(0, 4095)));
				write_config(CFG_SEED, 16'($urandom_range(1, 65535)));
			end
			if (k == QUIET_FROM) quiet = 1;
			random_op();
			maybe_gap();
		end
		cmd_valid <= 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		rsp_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 0;
				hold_req = 0;
			end else if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_stall <= 0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		core_result_t e;
		if (rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result transaction at %0t", $realtime);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) report("status", 16'(status), 16'(e.st));
				if (program_counter !== e.pc)
					report("program_counter", 16'(program_counter), 16'(e.pc));
				if (index_value !== e.idx) report("index_value", 16'(index_value), 16'(e.idx));
				if (flag_value !== e.vf) report("flag_value", 16'(flag_value), 16'(e.vf));
				if (pixel_value !== e.pix) report("pixel_value", 16'(pixel_value), 16'(e.pix));
				if (sound_value !== e.snd) report("sound_value", 16'(sound_value), 16'(e.snd));
				if (key_wait_pending !== e.wpend)
					report("key_wait_pending", 16'(key_wait_pending), 16'(e.wpend));
				if (key_wait_target !== e.wtgt)
					report("key_wait_target", 16'(key_wait_target), 16'(e.wtgt));
			end
		end
	end

	// watchdog: cycles without any transaction on any channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

endmodule
